// ----- src/tbd_pkg.sv -----
package tbd_pkg;

	localparam logic [7:0] LEADER_BYTE = 8'hFF;
	localparam logic [7:0] START_CHAR  = 8'h53;

	localparam logic [1:0] KIND_DATA      = 2'd0;
	localparam logic [1:0] KIND_SUM_OK    = 2'd1;
	localparam logic [1:0] KIND_SUM_ERR   = 2'd2;
	localparam logic [1:0] KIND_BAD_START = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] address;
		logic [7:0]  data;
		logic [7:0]  sum;
		logic        last;
	} res_t;

endpackage

// ----- src/tbd_core.sv -----
module tbd_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    byte_s1,
	output logic          push,
	output tbd_pkg::res_t res
);

	localparam logic [2:0] PH_HUNT   = 3'd0;
	localparam logic [2:0] PH_LEADER = 3'd1;
	localparam logic [2:0] PH_SA_HI  = 3'd2;
	localparam logic [2:0] PH_SA_LO  = 3'd3;
	localparam logic [2:0] PH_EA_HI  = 3'd4;
	localparam logic [2:0] PH_EA_LO  = 3'd5;
	localparam logic [2:0] PH_DATA   = 3'd6;
	localparam logic [2:0] PH_CSUM   = 3'd7;

	logic [2:0]  phase_q, phase_d;
	logic [7:0]  hold_q, hold_d;
	logic [15:0] start_q, start_d;
	logic [15:0] cur_q, cur_d;
	logic [16:0] left_q, left_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  sum_add;
	logic [15:0] end_addr;
	logic [16:0] left_dec;
	logic        emit;

	assign sum_add  = sum_q + byte_s1;
	assign end_addr = {hold_q, byte_s1};
	assign left_dec = left_q - 17'd1;

	always_comb begin
		phase_d = phase_q;
		hold_d  = hold_q;
		start_d = start_q;
		cur_d   = cur_q;
		left_d  = left_q;
		sum_d   = sum_q;
		emit    = 1'b0;
		res     = '0;
		case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == tbd_pkg::LEADER_BYTE) phase_d = PH_LEADER;
			end
			PH_LEADER: begin
				if (byte_s1 == tbd_pkg::LEADER_BYTE) begin
					phase_d = PH_LEADER;
				end else if (byte_s1 == tbd_pkg::START_CHAR) begin
					sum_d   = '0;
					phase_d = PH_SA_HI;
				end else begin
					phase_d  = PH_HUNT;
					emit     = 1'b1;
					res.kind = tbd_pkg::KIND_BAD_START;
					res.data = byte_s1;
					res.last = 1'b1;
				end
			end
			PH_SA_HI: begin
				sum_d   = sum_add;
				hold_d  = byte_s1;
				phase_d = PH_SA_LO;
			end
			PH_SA_LO: begin
				sum_d   = sum_add;
				start_d = {hold_q, byte_s1};
				phase_d = PH_EA_HI;
			end
			PH_EA_HI: begin
				sum_d   = sum_add;
				hold_d  = byte_s1;
				phase_d = PH_EA_LO;
			end
			PH_EA_LO: begin
				sum_d   = sum_add;
				// length wraps modulo 64k, so 1..65536 bytes
				left_d  = {1'b0, end_addr - start_q} + 17'd1;
				cur_d   = start_q;
				phase_d = PH_DATA;
			end
			PH_DATA: begin
				sum_d       = sum_add;
				emit        = 1'b1;
				res.kind    = tbd_pkg::KIND_DATA;
				res.address = cur_q;
				res.data    = byte_s1;
				cur_d       = cur_q + 16'd1;
				left_d      = left_dec;
				if (left_dec == 17'd0) phase_d = PH_CSUM;
			end
			default: begin
				sum_d    = sum_add;
				phase_d  = PH_HUNT;
				emit     = 1'b1;
				res.kind = (sum_add == 8'd0) ? tbd_pkg::KIND_SUM_OK : tbd_pkg::KIND_SUM_ERR;
				res.sum  = sum_add;
				res.last = 1'b1;
			end
		endcase
	end

	assign push = step & emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			hold_q  <= '0;
			start_q <= '0;
			cur_q   <= '0;
			left_q  <= '0;
			sum_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			hold_q  <= hold_d;
			start_q <= start_d;
			cur_q   <= cur_d;
			left_q  <= left_d;
			sum_q   <= sum_d;
		end
	end

endmodule

// ----- src/tbd_outbuf.sv -----
module tbd_outbuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tbd_pkg::res_t push_res,
	output logic          space,
	output logic          out_valid,
	input  logic          out_ready,
	output tbd_pkg::res_t out_res
);

	tbd_pkg::res_t ent_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign space     = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_res   = ent_q[rd_q];
	assign pop       = out_valid & out_ready;

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= push_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- src/tape_block_deframer.sv -----
// tape block deframer: turns a received byte stream into addressed data bytes
// input channel: rx_byte with in_valid / in_ready, one byte per transfer
// output channel: kind, address, data, sum, last with out_valid / out_ready
// kind 0 is a data byte with its address; kinds 1 and 2 close a block with
// checksum ok or error and the final sum; kind 3 reports a bad start character
// and carries the offending byte; last is set on every status result
// throughput: one byte per cycle while the result buffer has space
// path: a byte is registered at the input, the state logic forms its result,
// which is written into the result buffer and presented on the output from there
// leader, start character and address bytes produce no result
// a two-entry result buffer sits between the state logic and the output, so
// the input keeps taking bytes while a result waits; when the receiver stalls
// the buffer fills and in_ready then drops until results are taken
// reset: the block hunts for a leader byte and all buffers are empty
module tape_block_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [15:0] address,
	output logic [7:0]  data,
	output logic [7:0]  sum,
	output logic        last
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          space;
	logic          step;
	logic          push;
	tbd_pkg::res_t res;
	tbd_pkg::res_t out_res;

	assign step     = valid_s1 & space;
	assign in_ready = ~valid_s1 | step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) byte_s1 <= rx_byte;
	end

	tbd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_s1 (byte_s1),
		.push    (push),
		.res     (res)
	);

	tbd_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_res  (res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign kind    = out_res.kind;
	assign address = out_res.address;
	assign data    = out_res.data;
	assign sum     = out_res.sum;
	assign last    = out_res.last;

endmodule
